/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is high.
`define MFRQ_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mfrq assertion failed");

// Clocked assertion, active during reset as well.
`define MFRQ_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("mfrq assertion failed");

`endif

/* rtl/core/mfrq_pkg.sv */
`timescale 1ns / 1ps

package mfrq_pkg;

   localparam int MAX_DIM_DEF    = 128;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_XFORM = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] OP_VFLIP = 3'd1;
   localparam logic [2:0] OP_HFLIP = 3'd2;
   localparam logic [2:0] OP_ROTCW = 3'd3;
   localparam logic [2:0] OP_ROTCC = 3'd4;
   localparam logic [2:0] OP_QUADCW = 3'd5;
   localparam logic [2:0] OP_QUADCC = 3'd6;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         row_index;
      logic [6:0]         col_index;
      logic signed [31:0] elem_value;
      logic [2:0]         op_code;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [7:0]         cur_rows;
      logic [7:0]         cur_cols;
      logic               error_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
   } pos_type;

   // Force a count into [2, max_dim].
   function automatic logic [7:0] clamp_dim(input logic [7:0] v, input int max_dim);
      logic [7:0] res;
      res = v;
      if (v < 8'd2) begin
         res = 8'd2;
      end else if (int'(v) > max_dim) begin
         res = 8'(max_dim);
      end
      return res;
   endfunction

   // Destination of element (i, j) of an nr x nc matrix under op.
   function automatic pos_type xform_dest(input logic [2:0] op, input logic [7:0] i,
                                          input logic [7:0] j, input logic [7:0] nr,
                                          input logic [7:0] nc);
      pos_type    d;
      logic [7:0] hr;
      logic [7:0] hc;
      logic       bot;
      logic       right;
      hr    = nr >> 1;
      hc    = nc >> 1;
      bot   = (i >= hr);
      right = (j >= hc);
      d.row = i;
      d.col = j;
      case (op)
         OP_VFLIP: d.row = nr - 8'd1 - i;
         OP_HFLIP: d.col = nc - 8'd1 - j;
         OP_ROTCW: begin
            d.row = j;
            d.col = nr - 8'd1 - i;
         end
         OP_ROTCC: begin
            d.row = nc - 8'd1 - j;
            d.col = i;
         end
         OP_QUADCW: begin
            if (!bot && !right) d.col = j + hc;
            else if (!bot)      d.row = i + hr;
            else if (right)     d.col = j - hc;
            else                d.row = i - hr;
         end
         OP_QUADCC: begin
            if (!bot && !right) d.row = i + hr;
            else if (!bot)      d.col = j - hc;
            else if (right)     d.row = i - hr;
            else                d.col = j + hc;
         end
         default: d = '{row: i, col: j};
      endcase
      return d;
   endfunction

endpackage

/* rtl/core/matrix_flip_rotate_quadrant_engine_unit.sv */
`timescale 1ns / 1ps
// Write, read and refused transactions go from acceptance to the done state, then to the
// output register once it is free. Transform: copy pass plus move pass over the current
// region through the element and scratch memories, one entry per cycle each.
// One transaction in flight; the next is taken while a result waits to be taken.
// Reset is synchronous: control, counts (2 x 2) and orientation clear; memory
// contents stay undefined until written, no clearing pass.
module matrix_flip_rotate_quadrant_engine_unit
   import mfrq_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [7:0]      csr_wdata
);

   localparam int DIM_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W = 2 * DIM_W;

   typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_MOVE, ST_DONE} state_type;

   state_type             state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [2:0]            op_ff, op_in;
   logic                  err_ff, err_in;
   logic [7:0]            nr_ff, nr_in;
   logic [7:0]            nc_ff, nc_in;
   logic [7:0]            i_ff, i_in;
   logic [7:0]            j_ff, j_in;
   logic                  cp_pend_ff, cp_pend_in;
   logic                  mv_pend_ff, mv_pend_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic                  swapped_ff, swapped_in;
   logic [7:0]            row_count_ff, row_count_in;
   logic [7:0]            col_count_ff, col_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [7:0]            cur_nr;
   logic [7:0]            cur_nc;
   logic                  req_fire;
   logic                  in_range;
   logic                  op_known;
   logic                  op_quad;
   logic                  go_xform;
   logic [ADDR_W-1:0]     addr_req;
   logic [ADDR_W-1:0]     iter_addr;
   logic [ADDR_W-1:0]     dest_addr;
   pos_type               dest;
   logic                  last_pos;
   logic signed [31:0]    read_word;

   logic                  st_wr_en, st_rd_en, sc_wr_en, sc_rd_en;
   logic [ADDR_W-1:0]     st_wr_addr, st_rd_addr;
   logic [DATA_WIDTH-1:0] st_wr_data, st_rd_data, sc_rd_data;

   assign cur_nr = clamp_dim(swapped_ff ? col_count_ff : row_count_ff, MAX_DIM);
   assign cur_nc = clamp_dim(swapped_ff ? row_count_ff : col_count_ff, MAX_DIM);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_range = ({1'b0, req_data.row_index} < cur_nr) &&
                     ({1'b0, req_data.col_index} < cur_nc);
   assign op_quad  = (req_data.op_code == OP_QUADCW) || (req_data.op_code == OP_QUADCC);
   assign op_known = (req_data.op_code == OP_VFLIP) || (req_data.op_code == OP_HFLIP) ||
                     (req_data.op_code == OP_ROTCW) || (req_data.op_code == OP_ROTCC) ||
                     op_quad;
   assign go_xform = (req_data.kind == KIND_XFORM) && op_known &&
                     !(op_quad && (cur_nr[0] || cur_nc[0]));

   assign addr_req  = {DIM_W'(req_data.row_index), DIM_W'(req_data.col_index)};
   assign iter_addr = {DIM_W'(i_ff), DIM_W'(j_ff)};
   assign dest      = xform_dest(op_ff, i_ff, j_ff, nr_ff, nc_ff);
   assign dest_addr = {DIM_W'(dest.row), DIM_W'(dest.col)};
   assign last_pos  = (i_ff == nr_ff - 8'd1) && (j_ff == nc_ff - 8'd1);

   // Element memory: item writes and reads, copy-pass reads, move-pass writes.
   assign st_wr_en   = (req_fire && (req_data.kind == KIND_WRITE) && in_range) || mv_pend_ff;
   assign st_wr_addr = mv_pend_ff ? pend_addr_ff : addr_req;
   assign st_wr_data = mv_pend_ff ? sc_rd_data : DATA_WIDTH'(req_data.elem_value);
   assign st_rd_en   = (req_fire && (req_data.kind == KIND_READ) && in_range) ||
                       (state_ff == ST_COPY);
   assign st_rd_addr = (state_ff == ST_COPY) ? iter_addr : addr_req;

   // Scratch memory: filled by the copy pass, drained by the move pass.
   assign sc_wr_en = cp_pend_ff;
   assign sc_rd_en = (state_ff == ST_MOVE);

   mfrq_ram #(.DATA_WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   mfrq_ram #(.DATA_WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_scratch (
      .clock   (clock),
      .wr_en   (sc_wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (st_rd_data),
      .rd_en   (sc_rd_en),
      .rd_addr (iter_addr),
      .rd_data (sc_rd_data)
   );

   assign read_word = ((kind_ff == KIND_READ) && !err_ff) ? 32'(st_rd_data) : 32'sd0;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      nr_in        = nr_ff;
      nc_in        = nc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      swapped_in   = swapped_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cp_pend_in   = (state_ff == ST_COPY);
      mv_pend_in   = (state_ff == ST_MOVE);
      pend_addr_in = (state_ff == ST_COPY) ? iter_addr : dest_addr;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default:       row_count_in = row_count_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_data.kind;
               op_in   = req_data.op_code;
               nr_in   = cur_nr;
               nc_in   = cur_nc;
               i_in    = 8'd0;
               j_in    = 8'd0;
               err_in  = 1'b0;
               if ((req_data.kind == KIND_WRITE) || (req_data.kind == KIND_READ)) begin
                  err_in = !in_range;
               end else if (req_data.kind == KIND_XFORM) begin
                  err_in = op_quad && (cur_nr[0] || cur_nc[0]);
               end
               state_in = go_xform ? ST_COPY : ST_DONE;
            end
         end
         ST_COPY, ST_MOVE: begin
            if (j_ff == nc_ff - 8'd1) begin
               j_in = 8'd0;
               i_in = i_ff + 8'd1;
            end else begin
               j_in = j_ff + 8'd1;
            end
            if (last_pos) begin
               i_in = 8'd0;
               j_in = 8'd0;
               if (state_ff == ST_COPY) begin
                  state_in = ST_MOVE;
               end else begin
                  state_in = ST_DONE;
                  if ((op_ff == OP_ROTCW) || (op_ff == OP_ROTCC)) begin
                     swapped_in = !swapped_ff;
                  end
               end
            end
         end
         ST_DONE: begin
            // Hand over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_value = read_word;
               rsp_data_in.cur_rows   = cur_nr;
               rsp_data_in.cur_cols   = cur_nc;
               rsp_data_in.error_flag = err_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cp_pend_ff   <= 1'b0;
         mv_pend_ff   <= 1'b0;
         swapped_ff   <= 1'b0;
         row_count_ff <= 8'd2;
         col_count_ff <= 8'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cp_pend_ff   <= cp_pend_in;
         mv_pend_ff   <= mv_pend_in;
         swapped_ff   <= swapped_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      op_ff        <= op_in;
      err_ff       <= err_in;
      nr_ff        <= nr_in;
      nc_ff        <= nc_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/mfrq_ram.sv */
`timescale 1ns / 1ps

module mfrq_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 14
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mfrq_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfrq_checker
   import mfrq_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   `MFRQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `MFRQ_ASSERT(a_dims_min, rsp_valid |-> (rsp_data.cur_rows >= 8'd2) && (rsp_data.cur_cols >= 8'd2))
   `MFRQ_ASSERT(a_err_zero, rsp_valid && rsp_data.error_flag |-> rsp_data.read_value == 32'sd0)
   `MFRQ_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready)
   `MFRQ_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_valid)

endmodule

bind matrix_flip_rotate_quadrant_engine_unit mfrq_checker u_mfrq_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import mfrq_pkg::*;

   localparam int          MAX_DIM     = MAX_DIM_DEF;
   localparam int          STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned BIG_AREA    = 1024;

   // Codes the block has to ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] OP_NOP_LO   = 3'd0;
   localparam logic [2:0] OP_NOP_HI   = 3'd7;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic            csr_index = 1'b0;
   logic [7:0]      csr_wdata = 8'd0;

   // Matrix shadow: values, which entries hold a written value, orientation, counts.
   logic signed [31:0] elem_mem   [STORE_DEPTH];
   bit                 elem_known [STORE_DEPTH];
   logic signed [31:0] snap_mem   [STORE_DEPTH];
   bit                 snap_known [STORE_DEPTH];
   bit                 orient_swapped = 1'b0;
   logic [7:0]         row_reg        = 8'd2;
   logic [7:0]         col_reg        = 8'd2;

   rsp_payload_type expected_rsp_q [$];
   rsp_payload_type exp_head;

   int unsigned    fail_count      = 0;
   int unsigned    checked_count   = 0;
   int unsigned    item_count      = 0;
   int unsigned    xform_count     = 0;
   int unsigned    refused_count   = 0;
   int unsigned    shape_count     = 0;
   int unsigned    cycle_count     = 0;
   int unsigned    burst_left      = 0;
   ready_mode_type ready_mode      = READY_ALWAYS;
   int unsigned    ready_mode_left = 0;

   matrix_flip_rotate_quadrant_engine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: switch between always ready, coin flip and sparse ready.
   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      <= ready_mode_type'($urandom_range(0, 2));
         ready_mode_left <= $urandom_range(16, 160);
      end else begin
         ready_mode_left <= ready_mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         default:      rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("rsp transaction with no expected result pending");
            fail_count++;
         end else begin
            exp_head = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_data.read_value !== exp_head.read_value) begin
               $error("read_value: expected %0d, got %0d", exp_head.read_value,
                      rsp_data.read_value);
               fail_count++;
            end
            if (rsp_data.cur_rows !== exp_head.cur_rows) begin
               $error("cur_rows: expected %0d, got %0d", exp_head.cur_rows, rsp_data.cur_rows);
               fail_count++;
            end
            if (rsp_data.cur_cols !== exp_head.cur_cols) begin
               $error("cur_cols: expected %0d, got %0d", exp_head.cur_cols, rsp_data.cur_cols);
               fail_count++;
            end
            if (rsp_data.error_flag !== exp_head.error_flag) begin
               $error("error_flag: expected %0b, got %0b", exp_head.error_flag,
                      rsp_data.error_flag);
               fail_count++;
            end
         end
      end
   end

   function automatic int unsigned clamp_count(input logic [7:0] v);
      if (v < 8'd2) return 2;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int unsigned live_rows();
      return clamp_count(orient_swapped ? col_reg : row_reg);
   endfunction

   function automatic int unsigned live_cols();
      return clamp_count(orient_swapped ? row_reg : col_reg);
   endfunction

   // Move the nr x nc region; returns 1 when a quadrant cycle is refused.
   function automatic bit transform_matrix(input logic [2:0] op, input int unsigned nr,
                                           input int unsigned nc);
      int unsigned hr, hc, i, j, di, dj, src, dst;
      if (op < OP_VFLIP || op > OP_QUADCC) return 1'b0;
      if ((op == OP_QUADCW || op == OP_QUADCC) && ((nr % 2) != 0 || (nc % 2) != 0))
         return 1'b1;
      hr = nr / 2;
      hc = nc / 2;
      for (i = 0; i < nr; i++) begin
         for (j = 0; j < nc; j++) begin
            src             = i * MAX_DIM + j;
            snap_mem[src]   = elem_mem[src];
            snap_known[src] = elem_known[src];
         end
      end
      for (i = 0; i < nr; i++) begin
         for (j = 0; j < nc; j++) begin
            di = i;
            dj = j;
            case (op)
               OP_VFLIP: di = nr - 1 - i;
               OP_HFLIP: dj = nc - 1 - j;
               OP_ROTCW: begin
                  di = j;
                  dj = nr - 1 - i;
               end
               OP_ROTCC: begin
                  di = nc - 1 - j;
                  dj = i;
               end
               OP_QUADCW: begin
                  if (i < hr && j < hc) dj = j + hc;
                  else if (i < hr)      di = i + hr;
                  else if (j >= hc)     dj = j - hc;
                  else                  di = i - hr;
               end
               default: begin
                  if (i < hr && j < hc) di = i + hr;
                  else if (i < hr)      dj = j - hc;
                  else if (j >= hc)     di = i - hr;
                  else                  dj = j + hc;
               end
            endcase
            src             = i * MAX_DIM + j;
            dst             = (di * MAX_DIM + dj) % STORE_DEPTH;
            elem_mem[dst]   = snap_mem[src];
            elem_known[dst] = snap_known[src];
         end
      end
      if (op == OP_ROTCW || op == OP_ROTCC) orient_swapped = !orient_swapped;
      return 1'b0;
   endfunction

   function automatic rsp_payload_type predict_matrix_op(input req_payload_type t);
      rsp_payload_type r;
      int unsigned     nr, nc, a;
      nr = live_rows();
      nc = live_cols();
      r  = '0;
      case (t.kind)
         KIND_WRITE, KIND_READ: begin
            if (t.row_index >= nr || t.col_index >= nc) begin
               r.error_flag = 1'b1;
            end else begin
               a = t.row_index * MAX_DIM + t.col_index;
               if (t.kind == KIND_WRITE) begin
                  elem_mem[a]   = t.elem_value;
                  elem_known[a] = 1'b1;
               end else begin
                  r.read_value = elem_mem[a];
               end
            end
         end
         KIND_XFORM: r.error_flag = transform_matrix(t.op_code, nr, nc);
         default: ;
      endcase
      r.cur_rows = 8'(live_rows());
      r.cur_cols = 8'(live_cols());
      return r;
   endfunction

   function automatic req_payload_type mk_item(input logic [1:0] kind, input logic [6:0] row,
                                               input logic [6:0] col,
                                               input logic signed [31:0] value,
                                               input logic [2:0] op);
      req_payload_type t;
      t.kind       = kind;
      t.row_index  = row;
      t.col_index  = col;
      t.elem_value = value;
      t.op_code    = op;
      return t;
   endfunction

   function automatic logic [6:0] pick_coord(input int unsigned n);
      case ($urandom_range(0, 3))
         0:       return 7'd0;
         1:       return 7'(n - 1);
         default: return 7'($urandom_range(0, n - 1));
      endcase
   endfunction

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type make_random_item(input bit allow_xform,
                                                        output bit ignored);
      req_payload_type t;
      int unsigned     nr, nc, sel, tries;
      logic [6:0]      r, c;
      nr           = live_rows();
      nc           = live_cols();
      ignored      = 1'b0;
      t.kind       = KIND_WRITE;
      t.row_index  = pick_coord(nr);
      t.col_index  = pick_coord(nc);
      t.elem_value = random_word();
      t.op_code    = 3'($urandom_range(0, 7));
      sel          = $urandom_range(0, 99);
      if (sel >= 35 && sel < 65) begin
         // read only entries that hold a written value, else fall back to a write
         for (tries = 0; tries < 32; tries++) begin
            r = pick_coord(nr);
            c = pick_coord(nc);
            if (elem_known[r * MAX_DIM + c]) begin
               t.kind      = KIND_READ;
               t.row_index = r;
               t.col_index = c;
               break;
            end
         end
      end else if (sel >= 65 && sel < 88 && allow_xform) begin
         t.kind    = KIND_XFORM;
         t.op_code = 3'($urandom_range(OP_VFLIP, OP_QUADCC));
      end else if (sel >= 65 && sel < 95) begin
         if (nr < MAX_DIM && (nc == MAX_DIM || $urandom_range(0, 1) == 1))
            t.row_index = 7'($urandom_range(nr, 127));
         else if (nc < MAX_DIM)
            t.col_index = 7'($urandom_range(nc, 127));
         if (t.row_index >= nr || t.col_index >= nc)
            t.kind = ($urandom_range(0, 1) == 1) ? KIND_READ : KIND_WRITE;
      end else begin
         ignored = 1'b1;
         if ($urandom_range(0, 1) == 1) begin
            t.kind = KIND_UNUSED;
         end else begin
            t.kind    = KIND_XFORM;
            t.op_code = ($urandom_range(0, 1) == 1) ? OP_NOP_HI : OP_NOP_LO;
         end
      end
      return t;
   endfunction

   task automatic send_item(input req_payload_type t);
      rsp_payload_type exp_rsp;
      int unsigned     gap_len;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_rsp = predict_matrix_op(t);
      expected_rsp_q.push_back(exp_rsp);
      item_count++;
      if (t.kind == KIND_XFORM && t.op_code >= OP_VFLIP && t.op_code <= OP_QUADCC) begin
         xform_count++;
         if (exp_rsp.error_flag) refused_count++;
      end
   endtask

   // Hold off the sender until every expected result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic configure_dims(input logic [7:0] rows, input logic [7:0] cols);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      row_reg = rows;
      csr_index <= CSR_COL_COUNT;
      csr_wdata <= cols;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      col_reg = cols;
      csr_valid <= 1'b0;
      shape_count++;
   endtask

   task automatic test_element_access();
      send_item(mk_item(KIND_WRITE, 7'd0, 7'd0, 32'sh7fffffff, OP_NOP_LO));
      send_item(mk_item(KIND_WRITE, 7'd1, 7'd1, 32'sh80000000, OP_NOP_HI));
      send_item(mk_item(KIND_WRITE, 7'd0, 7'd1, 32'sd0, OP_QUADCC));
      send_item(mk_item(KIND_WRITE, 7'd1, 7'd0, -32'sd1, OP_VFLIP));
      send_item(mk_item(KIND_READ, 7'd0, 7'd0, -32'sd1, OP_NOP_HI));
      send_item(mk_item(KIND_READ, 7'd1, 7'd1, 32'sd0, OP_NOP_LO));
      // out of range: the write is dropped, the read answers zero
      send_item(mk_item(KIND_WRITE, 7'd127, 7'd0, 32'sd5, OP_NOP_LO));
      send_item(mk_item(KIND_READ, 7'd0, 7'd127, 32'sd0, OP_NOP_LO));
      send_item(mk_item(KIND_UNUSED, 7'd127, 7'd127, -32'sd1, OP_NOP_HI));
   endtask

   task automatic test_transform_ops();
      logic [2:0] op;
      for (op = OP_VFLIP; op <= OP_QUADCC; op++) begin
         send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, op));
         send_item(mk_item(KIND_READ, 7'(op[0]), 7'(op[1]), 32'sd0, OP_NOP_LO));
      end
      send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, OP_NOP_LO));
      send_item(mk_item(KIND_XFORM, 7'd127, 7'd127, -32'sd1, OP_NOP_HI));
   endtask

   task automatic test_count_registers();
      configure_dims(8'd3, 8'd4);
      send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, OP_QUADCW));
      send_item(mk_item(KIND_READ, 7'd1, 7'd1, 32'sd0, OP_NOP_LO));
      send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, OP_ROTCW));
      send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, OP_QUADCC));
      // below-minimum and above-maximum counts clamp; orientation is kept
      configure_dims(8'd0, 8'd255);
      send_item(mk_item(KIND_UNUSED, 7'd0, 7'd0, 32'sd0, OP_NOP_LO));
      send_item(mk_item(KIND_XFORM, 7'd0, 7'd0, 32'sd0, OP_QUADCC));
   endtask

   task automatic test_random_traffic();
      logic [7:0]      shape_rows [8];
      logic [7:0]      shape_cols [8];
      req_payload_type t;
      bit              ignored;
      int unsigned     p, n, xform_done, xform_cap;
      shape_rows = '{8'd4, 8'd3, 8'd128, 8'd2, 8'd7, 8'd1, 8'd6, 8'd129};
      shape_cols = '{8'd6, 8'd5, 8'd128, 8'd2, 8'd2, 8'd255, 8'd4, 8'd8};
      for (p = 0; p < 8; p++) begin
         configure_dims(shape_rows[p], shape_cols[p]);
         // transforms over a region larger than BIG_AREA are slow; allow only three
         xform_cap  = (live_rows() * live_cols() > BIG_AREA) ? 3 : 1000;
         xform_done = 0;
         n          = 0;
         while (n < 9) begin
            t = make_random_item(xform_done < xform_cap, ignored);
            send_item(t);
            if (!ignored) begin
               if (t.kind == KIND_XFORM) xform_done++;
               n++;
               if (p == 1 && n == 6) wait_idle();
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_element_access();
      test_transform_ops();
      test_count_registers();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Ran %0d transactions over %0d register settings: %0d transforms, %0d refused",
               item_count, shape_count, xform_count, refused_count);
      $display("Compared %0d results field by field, %0d mismatches", checked_count,
               fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mfrq_pkg.sv
rtl/core/mfrq_ram.sv
rtl/core/matrix_flip_rotate_quadrant_engine_unit.sv
rtl/core/mfrq_checker.sv
dv/tb.sv
